@@ sv/twister_keystream_byte_cipher_defines.svh @@
// Assertion helpers shared by the RTL files.
`ifndef TWISTER_KEYSTREAM_BYTE_CIPHER_DEFINES_SVH
`define TWISTER_KEYSTREAM_BYTE_CIPHER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TWK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TWK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/twk_pkg.sv @@
`timescale 1ns / 1ps
package twk_pkg;

    localparam int STATE_WORDS       = 624;
    localparam int RECURRENCE_OFFSET = 397;
    localparam int IDX_W             = 10;
    localparam int WORD_W            = 32;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

    typedef enum logic [2:0] {
        ST_READY,
        ST_SEED,
        ST_PRIME,
        ST_LOAD,
        ST_PEND
    } t_state;

    typedef struct packed {
        logic seed_start;
        logic seed_run;
        logic prime;
        logic load;
        logic emit;
        logic use_held;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic seed_last;
    } t_dp_status;

endpackage

@@ sv/twk_stream_if.sv @@
`timescale 1ns / 1ps
interface twk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface twk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink (input valid, input out_byte, output ready);
endinterface

@@ sv/twk_ram.sv @@
`timescale 1ns / 1ps
module twk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ sv/twk_ctrl.sv @@
`timescale 1ns / 1ps
`include "twister_keystream_byte_cipher_defines.svh"
module twk_ctrl
    import twk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_restart,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_READY;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_READY: begin
                if (accept && i_in_restart) begin
                    n_state = ST_SEED;
                end
            end
            ST_SEED: begin
                if (i_status.seed_last) begin
                    n_state = ST_PRIME;
                end
            end
            ST_PRIME: n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_PEND;
            ST_PEND: begin
                if (i_status.out_free) begin
                    n_state = ST_READY;
                end
            end
            default:  n_state = ST_READY;
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == ST_READY) && i_status.out_free;
        accept           = o_in_ready && i_in_valid;
        o_cmd.seed_start = accept && i_in_restart;
        o_cmd.seed_run   = (r_state == ST_SEED);
        o_cmd.prime      = (r_state == ST_PRIME);
        o_cmd.load       = (r_state == ST_LOAD);
        o_cmd.use_held   = (r_state == ST_PEND);
        // a held restart byte goes out once the table is primed
        o_cmd.emit       = (accept && !i_in_restart)
                         || ((r_state == ST_PEND) && i_status.out_free);
    end

    `TWK_ASSERT_NOW(a_emit_needs_slot, o_cmd.emit, i_status.out_free, "emit without free slot")
    `TWK_ASSERT_NEXT(a_seed_to_prime, o_cmd.seed_run && i_status.seed_last, r_state == ST_PRIME, "no prime")
    `TWK_ASSERT_NEXT(a_restart_seeds, o_cmd.seed_start, r_state == ST_SEED, "restart did not seed")

endmodule

@@ sv/twk_datapath.sv @@
`timescale 1ns / 1ps
`include "twister_keystream_byte_cipher_defines.svh"
module twk_datapath
    import twk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WORD_W-1:0] i_cfg_wdata,
    input  t_dp_cmd           i_cmd,
    input  logic [7:0]        i_data_byte,
    output t_dp_status        o_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte
);

    localparam logic [WORD_W-1:0] MATRIX    = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C  = 32'hEFC6_0000;
    localparam logic [WORD_W-1:0] LCG_MUL   = 32'd69069;
    localparam logic [63:0]       LCG_SQ    = 64'(LCG_MUL) * 64'(LCG_MUL);
    localparam logic [WORD_W-1:0] LCG_MUL2  = LCG_SQ[WORD_W-1:0];
    localparam logic [WORD_W-1:0] LCG_ADD2  = LCG_MUL + 32'd1;
    localparam logic [IDX_W:0]    OFFSET    = (IDX_W+1)'(RECURRENCE_OFFSET);
    localparam logic [IDX_W:0]    WORDS_EXT = (IDX_W+1)'(STATE_WORDS);

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        t = w ^ (w >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    logic [WORD_W-1:0] r_seed_value;
    logic [WORD_W-1:0] r_x;
    logic [IDX_W-1:0]  r_scnt;
    logic [IDX_W-1:0]  r_idx;
    logic [WORD_W-1:0] r_cur;
    logic [7:0]        r_held;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;

    logic [WORD_W-1:0] rd_a;
    logic [WORD_W-1:0] rd_b;
    logic [WORD_W-1:0] x1;
    logic [WORD_W-1:0] x2;
    logic [WORD_W-1:0] seed_word;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] twisted;
    logic [WORD_W-1:0] tempered;
    logic [7:0]        data_sel;
    logic [IDX_W-1:0]  idx_inc;
    logic [IDX_W-1:0]  idx_eff;
    logic [IDX_W-1:0]  eff_inc;
    logic [IDX_W:0]    far_sum;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;

    // two LCG steps per word, both taken from the same state
    assign x1        = r_x * LCG_MUL + 32'd1;
    assign x2        = r_x * LCG_MUL2 + LCG_ADD2;
    assign seed_word = {r_x[31:16], x1[31:16]};

    // in-place twist of the word about to be tempered
    assign y        = {r_cur[31], rd_a[30:0]};
    assign twisted  = rd_b ^ (y >> 1) ^ (y[0] ? MATRIX : '0);
    assign tempered = temper(twisted);
    assign data_sel = i_cmd.use_held ? r_held : i_data_byte;

    // advance read addresses together with an emit so data is ready next cycle
    always_comb begin
        idx_inc = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
        idx_eff = i_cmd.emit ? idx_inc : r_idx;
        eff_inc = (idx_eff == LAST_IDX) ? '0 : idx_eff + 1'b1;
        far_sum = {1'b0, idx_eff} + OFFSET;
        raddr_a = i_cmd.prime ? r_idx : eff_inc;
        raddr_b = (far_sum >= WORDS_EXT) ? IDX_W'(far_sum - WORDS_EXT) : far_sum[IDX_W-1:0];
    end

    always_comb begin
        we    = i_cmd.seed_run || i_cmd.emit;
        waddr = i_cmd.seed_run ? r_scnt : r_idx;
        wdata = i_cmd.seed_run ? seed_word : twisted;
    end

    twk_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_value <= '0;
            r_scnt       <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed_value <= i_cfg_wdata;
            end
            if (i_cmd.seed_start) begin
                r_scnt <= '0;
                r_idx  <= '0;
            end else if (i_cmd.seed_run) begin
                r_scnt <= r_scnt + 1'b1;
            end else if (i_cmd.emit) begin
                r_idx <= idx_inc;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_start) begin
            r_x    <= r_seed_value;
            r_held <= i_data_byte;
        end else if (i_cmd.seed_run) begin
            r_x <= x2;
        end
        if (i_cmd.load || i_cmd.emit) begin
            r_cur <= rd_a;
        end
        if (i_cmd.emit) begin
            r_out_byte <= data_sel ^ tempered[7:0];
        end
    end

    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.seed_last = (r_scnt == LAST_IDX);
    assign o_out_valid        = r_out_valid;
    assign o_out_byte         = r_out_byte;

    `TWK_ASSERT_NEXT(a_emit_fills_out, i_cmd.emit, r_out_valid, "result not presented")
    `TWK_ASSERT_NEXT(a_idx_wraps, i_cmd.emit && (r_idx == LAST_IDX), r_idx == '0, "no wrap")
    `TWK_ASSERT_NOW(a_no_emit_in_seed, i_cmd.seed_run, !i_cmd.emit, "twist write during seeding")

endmodule

@@ sv/twister_keystream_byte_cipher.sv @@
// Byte stream cipher keyed by a tempered MT19937 generator. Every byte on the
// input channel comes back on the output channel XORed with the low byte of
// one generator word, so the same block encrypts and decrypts.
// Input channel: data_byte plus restart. Output channel: out_byte.
// Config port: i_cfg_we / i_cfg_wdata load the 32-bit seed, which takes effect
// at the next transaction that carries restart.
// A plain byte's result is registered and shows on the output in the cycle
// after its transaction; without receiver stalls, throughput is one byte per
// cycle, set by the two-read-port state RAM, which twists each table word in
// place just before it is tempered. A restart byte seeds the 624-word table,
// one word per cycle over the RAM write port, then primes the read registers
// before its result is registered; no input is taken meanwhile.
// Reset clears the seed register and the output valid flag; the table is not
// cleared, so the first transaction after reset must carry restart.
// While the receiver stalls, the result is held and the input side takes a new
// byte only in the cycle the held result is taken.
`timescale 1ns / 1ps
module twister_keystream_byte_cipher
    import twk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WORD_W-1:0] i_cfg_wdata,
    twk_in_if.sink            i_in,
    twk_out_if.source         o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;

    twk_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_restart (i_in.restart),
        .o_in_ready   (i_in.ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    twk_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_data_byte (i_in.data_byte),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_byte  (o_out.out_byte)
    );

endmodule

@@ tb/twister_keystream_byte_cipher_checker.sv @@
`timescale 1ns / 1ps
module twister_keystream_byte_cipher_checker
    import twk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WORD_W-1:0] i_cfg_wdata,
    twk_in_if                 i_in,
    twk_out_if                i_out,
    output int                o_fail_count,
    output int                o_pending
);

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] TEMPER_MASK_B = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_MASK_C = 32'hEFC6_0000;
    localparam logic [WORD_W-1:0] UPPER_BIT = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_BITS = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] HALF_MASK = 32'hFFFF_0000;
    localparam logic [WORD_W-1:0] LCG_MUL = 32'd69069;

    logic [WORD_W-1:0] key_table [STATE_WORDS];
    int unsigned       key_index;
    logic [WORD_W-1:0] seed_reg;
    logic [7:0]        expected_bytes [$];
    int                fail_count = 0;
    int                pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending = pending_count;

    // Two LCG steps per word; the upper halves of both states form the word.
    function automatic void seed_key_table(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] upper;
        x = seed;
        for (int k = 0; k < STATE_WORDS; k++) begin
            upper = x & HALF_MASK;
            x = x * LCG_MUL + 32'd1;
            key_table[k] = upper | ((x & HALF_MASK) >> 16);
            x = x * LCG_MUL + 32'd1;
        end
        key_index = STATE_WORDS;
    endfunction

    function automatic void twist_key_table();
        logic [WORD_W-1:0] y;
        int                next_k;
        int                far_k;
        for (int k = 0; k < STATE_WORDS; k++) begin
            next_k = (k + 1) % STATE_WORDS;
            far_k = (k + RECURRENCE_OFFSET) % STATE_WORDS;
            y = (key_table[k] & UPPER_BIT) | (key_table[next_k] & LOWER_BITS);
            key_table[k] = key_table[far_k] ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
        end
        key_index = 0;
    endfunction

    function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y ^= y >> 11;
        y ^= (y << 7) & TEMPER_MASK_B;
        y ^= (y << 15) & TEMPER_MASK_C;
        y ^= y >> 18;
        return y;
    endfunction

    function automatic logic [7:0] next_key_byte(input logic restart);
        logic [WORD_W-1:0] w;
        if (restart)
            seed_key_table(seed_reg);
        if (key_index >= STATE_WORDS)
            twist_key_table();
        w = temper_word(key_table[key_index]);
        key_index++;
        return w[7:0];
    endfunction

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            seed_reg = '0;
            key_index = STATE_WORDS;
            foreach (key_table[k])
                key_table[k] = '0;
            expected_bytes.delete();
        end else begin
            // Retire the output first: a byte can never come back in its own cycle.
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                if (expected_bytes.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected out_byte, expected none, actual %02h",
                             $time, i_out.out_byte);
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out.out_byte !== want) begin
                        fail_count++;
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want, i_out.out_byte);
                    end
                end
            end
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1)
                expected_bytes.push_back(i_in.data_byte ^ next_key_byte(i_in.restart));
            if (i_cfg_we)
                seed_reg = i_cfg_wdata;
        end
        pending_count = expected_bytes.size();
    end

endmodule

@@ tb/twister_keystream_byte_cipher_tb.sv @@
`timescale 1ns / 1ps
module twister_keystream_byte_cipher_tb;
    import twk_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int TOTAL_BYTES = 1300;
    localparam int LONG_RUN_BYTES = 700;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES = 20;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [WORD_W-1:0] cfg_wdata;
    int                fail_count;
    int                pending;
    int                bytes_sent;
    bit                in_steady;

    twk_in_if  in_ch ();
    twk_out_if out_ch ();

    always #6 clk = ~clk;

    twister_keystream_byte_cipher u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    twister_keystream_byte_cipher_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [WORD_W-1:0] pick_seed();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Called and returns at a falling edge.
    task automatic send_byte(input logic [7:0] data, input logic restart);
        int gap;
        gap = in_steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= data;
        in_ch.restart <= restart;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Hold the input idle until every transaction has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_seed(input logic [WORD_W-1:0] seed);
        cfg_we <= 1'b1;
        cfg_wdata <= seed;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int n;
        bit first_phase;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.restart = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        in_steady = 1'b0;
        bytes_sent = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        write_seed('0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        // restart in the middle of a stream
        send_byte(8'hFF, 1'b1);
        send_byte(8'h7F, 1'b0);
        // new seed must stay unused until the next restart
        drain();
        write_seed('1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b0);
        drain();
        write_seed(32'h8000_0000);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        drain();
        write_seed(32'h0000_0001);
        send_byte(8'h12, 1'b1);

        // The first random run is long enough to wrap the table.
        first_phase = 1'b1;
        while (bytes_sent < TOTAL_BYTES) begin
            drain();
            in_steady = ($urandom_range(0, 3) == 0);
            if (first_phase || $urandom_range(0, 3) != 0)
                write_seed(pick_seed());
            n = first_phase ? LONG_RUN_BYTES : $urandom_range(10, 150);
            send_byte(8'($urandom), first_phase || $urandom_range(0, 3) != 0);
            for (int i = 1; i < n; i++)
                send_byte(8'($urandom), !first_phase && $urandom_range(0, 199) == 0);
            first_phase = 1'b0;
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Receiver stalls, with stall-free stretches now and then.
    initial begin
        int stall_left;
        int stretch_left;
        bit out_steady;
        out_ch.ready = 1'b0;
        stall_left = 0;
        stretch_left = 0;
        out_steady = 1'b0;
        forever begin
            @(negedge clk);
            if (stretch_left == 0) begin
                out_steady = ($urandom_range(0, 3) == 0);
                stretch_left = $urandom_range(50, 400);
            end else begin
                stretch_left--;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!out_steady && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
